### rtl/core/fan_curve_interpolator_unit_macros.svh
// ----------------------------------------------------------------------------
// fan_curve_interpolator_unit_macros.svh
// Assertion macros used by the verification code of the fan curve unit.
// ----------------------------------------------------------------------------
`ifndef FAN_CURVE_INTERPOLATOR_UNIT_MACROS_SVH
`define FAN_CURVE_INTERPOLATOR_UNIT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define FCI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define FCI_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  `FCI_ASSERT(lbl, clk, rstn, !(expr), msg)

`endif

### rtl/core/fci_pkg.sv
// ----------------------------------------------------------------------------
// fci_pkg
// Types and constants of the fan curve interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fci_pkg;

  // Field widths of the curve table and the stream items.
  localparam int TEMP_W         = 8;
  localparam int FAN_W          = 7;
  localparam int SLOT_W         = 16;
  localparam int SLOTS_PER_WORD = 4;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int COUNT_FIELD_W  = 5;

  // Product of a fan difference magnitude and a temperature offset.
  localparam int PROD_W = FAN_W + TEMP_W;
  // The quotient never exceeds the fan difference, so it fits the fan width.
  localparam int QUO_W  = FAN_W;

  localparam logic [FAN_W-1:0] FAN_MAX = FAN_W'(100);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POINTS_0_3   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS_4_7   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS_8_11  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS_12_15 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT  = 3'd4;

  // Segment found for one item; direct set means f0 already is the answer.
  typedef struct packed {
    logic                     direct;
    logic [FAN_W-1:0]         f0;
    logic signed [FAN_W:0]    df;
    logic [TEMP_W-1:0]        off;
    logic [TEMP_W-1:0]        dt;
  } seg_t;

  // One item on its way through the divider.
  typedef struct packed {
    logic                     direct;
    logic [FAN_W-1:0]         f0;
    logic                     neg;
    logic [PROD_W-1:0]        rem;
    logic [TEMP_W-1:0]        dt;
    logic [QUO_W-1:0]         quo;
  } div_st_t;

endpackage

### rtl/core/fci_seg_find.sv
// ----------------------------------------------------------------------------
// fci_seg_find
// Two pipeline stages: compares against every setpoint, then picks the
// first matching segment and forms its differences.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fci_seg_find import fci_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [TEMP_W-1:0]                     temps_i [MAX_POINTS],
  input  logic [FAN_W-1:0]                      fans_i  [MAX_POINTS],
  input  logic [$clog2(MAX_POINTS+1)-1:0]       count_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [TEMP_W-1:0]                     in_temp_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output seg_t                                  out_seg_o
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int SEG_N = MAX_POINTS - 1;

  // Stage A registers.
  logic                 a_v_q;
  logic [TEMP_W-1:0]    a_t_q;
  logic [SEG_N-1:0]     a_hit_q;
  logic                 a_empty_q, a_first_q, a_last_q;
  logic [IDX_W-1:0]     a_last_idx_q;
  logic                 a_rdy;

  // Stage B registers.
  logic                 b_v_q;
  seg_t                 b_q;
  logic                 b_rdy;

  // Stage A combinational compares.
  logic [SEG_N-1:0]     hit_d;
  logic [IDX_W-1:0]     last_idx_d;
  logic                 empty_d, first_d, last_d;

  always_comb begin
    for (int i = 0; i < SEG_N; i++) begin
      hit_d[i] = (CNT_W'(i + 1) < count_i) && (in_temp_i >= temps_i[i])
                 && (in_temp_i <= temps_i[i+1]);
    end
    empty_d    = (count_i == '0);
    last_idx_d = IDX_W'(count_i - CNT_W'(1));
    first_d    = (in_temp_i <= temps_i[0]);
    last_d     = (in_temp_i >= temps_i[last_idx_d]);
  end

  assign a_rdy = !a_v_q || b_rdy;
  assign b_rdy = !b_v_q || out_ready_i;
  assign in_ready_o = a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (a_rdy) begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && in_valid_i) begin
      a_t_q        <= in_temp_i;
      a_hit_q      <= hit_d;
      a_empty_q    <= empty_d;
      a_first_q    <= first_d;
      a_last_q     <= last_d;
      a_last_idx_q <= last_idx_d;
    end
  end

  // Stage B: first matching segment and its differences.
  logic [IDX_W-1:0]  sel;
  logic [IDX_W-1:0]  sel_hi;
  logic [TEMP_W-1:0] t0, t1;
  logic [FAN_W-1:0]  f0, f1;
  seg_t              b_d;

  always_comb begin
    sel = '0;
    for (int i = SEG_N - 1; i >= 0; i--) begin
      if (a_hit_q[i]) begin
        sel = IDX_W'(i);
      end
    end
    sel_hi = IDX_W'(sel + IDX_W'(1));
    t0 = temps_i[sel];
    t1 = temps_i[sel_hi];
    f0 = fans_i[sel];
    f1 = fans_i[sel_hi];

    b_d.direct = 1'b0;
    b_d.f0     = f0;
    b_d.df     = $signed({1'b0, f1}) - $signed({1'b0, f0});
    b_d.off    = a_t_q - t0;
    b_d.dt     = t1 - t0;

    // Special cases resolve to a value that is passed through untouched.
    if (a_empty_q) begin
      b_d.direct = 1'b1;
      b_d.f0     = '0;
    end else if (a_first_q) begin
      b_d.direct = 1'b1;
      b_d.f0     = fans_i[0];
    end else if (a_last_q) begin
      b_d.direct = 1'b1;
      b_d.f0     = fans_i[a_last_idx_q];
    end else if (a_hit_q == '0) begin
      b_d.direct = 1'b1;
      b_d.f0     = fans_i[0];
    end else if (t1 == t0) begin
      b_d.direct = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (b_rdy) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_rdy && a_v_q) begin
      b_q <= b_d;
    end
  end

  assign out_valid_o = b_v_q;
  assign out_seg_o   = b_q;

endmodule

### rtl/core/fci_divider.sv
// ----------------------------------------------------------------------------
// fci_divider
// Pipelined restoring divider: one quotient bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fci_divider import fci_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  div_st_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output div_st_t out_data_o
);

  div_st_t          data_w [QUO_W+1];
  logic [QUO_W:0]   valid_w;
  logic [QUO_W:0]   ready_w;
  logic [QUO_W-1:0] v_q;
  div_st_t          st_q [QUO_W];

  assign data_w[0]      = in_data_i;
  assign valid_w[0]     = in_valid_i;
  assign in_ready_o     = ready_w[0];
  assign ready_w[QUO_W] = out_ready_i;
  assign out_valid_o    = valid_w[QUO_W];
  assign out_data_o     = data_w[QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int BIT = QUO_W - 1 - k;

    logic [PROD_W-1:0] dvs;
    logic [PROD_W:0]   diff;
    div_st_t           st_d;

    // Trial subtraction of the shifted divisor.
    always_comb begin
      st_d = data_w[k];
      dvs  = PROD_W'(data_w[k].dt) << BIT;
      diff = {1'b0, data_w[k].rem} - {1'b0, dvs};
      if (!diff[PROD_W]) begin
        st_d.rem      = diff[PROD_W-1:0];
        st_d.quo[BIT] = 1'b1;
      end
    end

    assign ready_w[k] = !v_q[k] || ready_w[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (ready_w[k]) begin
        v_q[k] <= valid_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ready_w[k] && valid_w[k]) begin
        st_q[k] <= st_d;
      end
    end

    assign data_w[k+1]  = st_q[k];
    assign valid_w[k+1] = v_q[k];
  end

endmodule

### rtl/core/fan_curve_interpolator_unit.sv
// ----------------------------------------------------------------------------
// fan_curve_interpolator_unit
// Maps a temperature item to a fan duty percent along a setpoint curve.
// ----------------------------------------------------------------------------
// Usage:
//   The curve is loaded through the cfg write channel: indexes 0 to 3 carry
//   four 16-bit setpoints each (temperature in bits 7:0, fan percent in
//   bits 14:8), index 4 carries the number of valid setpoints. Write the
//   curve only while no item is in flight; cfg_ready_o is always high.
//   Temperature items enter on s_axis, fan percent items leave on m_axis,
//   one result per input, in order.
//   The pipeline has two stages of segment search, one multiply stage,
//   seven divider stages (one quotient bit each) and the output register.
//   Throughput is one item per cycle; every stage holds its own valid bit.
//   When m_axis stalls, the stages fill up one by one, and s_axis_tready
//   drops only once every stage holds an item. Nothing is lost or repeated.
//   Reset empties the pipeline and clears the curve to all zeros.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fan_curve_interpolator_unit import fci_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input items.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] temperature
  // Result items.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata    // [6:0] fan_percent, [7] zero
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  // Curve storage.
  logic [TEMP_W-1:0] temp_q [MAX_POINTS];
  logic [FAN_W-1:0]  fan_q  [MAX_POINTS];
  logic [CNT_W-1:0]  count_q, count_d;
  logic              cfg_fire;
  logic [COUNT_FIELD_W-1:0] count_field;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  for (genvar p = 0; p < MAX_POINTS; p++) begin : g_point
    localparam int LSB = (p % SLOTS_PER_WORD) * SLOT_W;

    logic [FAN_W-1:0] fan_raw;
    logic             wr;

    assign fan_raw = cfg_data_i[LSB+TEMP_W +: FAN_W];
    assign wr = cfg_fire
                && (cfg_index_i == REG_POINTS_0_3 + CFG_IDX_W'(p / SLOTS_PER_WORD));

    // Fan values above full duty are saturated on write.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        temp_q[p] <= '0;
        fan_q[p]  <= '0;
      end else if (wr) begin
        temp_q[p] <= cfg_data_i[LSB +: TEMP_W];
        fan_q[p]  <= (fan_raw > FAN_MAX) ? FAN_MAX : fan_raw;
      end
    end
  end

  // The point count is clamped to the table size.
  assign count_field = cfg_data_i[COUNT_FIELD_W-1:0];
  assign count_d = (count_field > COUNT_FIELD_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                             : CNT_W'(count_field);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_fire && (cfg_index_i == REG_POINT_COUNT)) begin
      count_q <= count_d;
    end
  end

  // Segment search.
  logic seg_valid, seg_ready;
  seg_t seg;

  fci_seg_find #(
    .MAX_POINTS (MAX_POINTS)
  ) u_seg_find (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .temps_i     (temp_q),
    .fans_i      (fan_q),
    .count_i     (count_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_temp_i   (s_axis_tdata[TEMP_W-1:0]),
    .out_valid_o (seg_valid),
    .out_ready_i (seg_ready),
    .out_seg_o   (seg)
  );

  // Multiply stage: magnitude of the fan difference times the offset.
  logic             m_v_q;
  div_st_t          m_q, m_d;
  logic             div_ready;
  logic [FAN_W-1:0] df_abs;

  always_comb begin
    df_abs     = seg.df[FAN_W] ? FAN_W'(-seg.df) : FAN_W'(seg.df);
    m_d.direct = seg.direct;
    m_d.f0     = seg.f0;
    m_d.neg    = seg.df[FAN_W];
    m_d.rem    = df_abs * seg.off;
    m_d.dt     = seg.dt;
    m_d.quo    = '0;
  end

  assign seg_ready = !m_v_q || div_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (seg_ready) begin
      m_v_q <= seg_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_ready && seg_valid) begin
      m_q <= m_d;
    end
  end

  // Divider.
  logic    div_valid, o_rdy;
  div_st_t div_out;

  fci_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (m_v_q),
    .in_ready_o  (div_ready),
    .in_data_i   (m_q),
    .out_valid_o (div_valid),
    .out_ready_i (o_rdy),
    .out_data_o  (div_out)
  );

  // Output register: apply the signed quotient to the first fan value.
  logic             o_v_q;
  logic [FAN_W-1:0] o_fan_q, o_fan_d;
  logic [FAN_W:0]   sum;

  always_comb begin
    if (div_out.neg) begin
      sum = {1'b0, div_out.f0} - {1'b0, div_out.quo};
    end else begin
      sum = {1'b0, div_out.f0} + {1'b0, div_out.quo};
    end
    o_fan_d = div_out.direct ? div_out.f0 : sum[FAN_W-1:0];
  end

  assign o_rdy = !o_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (o_rdy) begin
      o_v_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_rdy && div_valid) begin
      o_fan_q <= o_fan_d;
    end
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = {1'b0, o_fan_q};

endmodule

### rtl/core/fci_checker.sv
// ----------------------------------------------------------------------------
// fci_checker
// Port-level checks of the fan curve interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fan_curve_interpolator_unit_macros.svh"

module fci_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // Items accepted but not yet delivered.
  logic [7:0] pend_q, pend_d;
  logic       in_fire, out_fire;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  always_comb begin
    pend_d = pend_q;
    if (in_fire && !out_fire) begin
      pend_d = pend_q + 8'd1;
    end else if (out_fire && !in_fire) begin
      pend_d = pend_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // A result is always a valid duty percent with the pad bit clear.
  `FCI_ASSERT(a_fan_range, clk_i, rst_ni,
    m_axis_tvalid |-> (m_axis_tdata[6:0] <= 7'd100 && !m_axis_tdata[7]),
    "fan percent out of range")

  // No result without an item that caused it.
  `FCI_ASSERT_NEVER(a_no_invented, clk_i, rst_ni, out_fire && pend_q == 8'd0,
    "result delivered with no item in flight")

  // An empty pipeline always takes an item.
  `FCI_ASSERT(a_ready_when_empty, clk_i, rst_ni, (pend_q == 8'd0) |-> s_axis_tready,
    "input stalled while the pipeline is empty")

  // A stalled result holds.
  `FCI_ASSERT(a_out_hold, clk_i, rst_ni,
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)),
    "stalled result changed")

endmodule

bind fan_curve_interpolator_unit fci_checker u_fci_checker (.*);
